// ===== sv/mtt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_pkg
// Types and constants shared by the timer table modules.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int NUM_TIMERS_DEF = 32;
  localparam int OUT_MAX        = 32;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_FREE  = 3'd1,
    CMD_SET   = 3'd2,
    CMD_START = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_e_t;

  localparam logic [1:0] STAT_FREE  = 2'd0;
  localparam logic [1:0] STAT_ALLOC = 2'd1;
  localparam logic [1:0] STAT_USING = 2'd2;

  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_READ   = 2'd1,
    S_EVAL   = 2'd2,
    S_FINISH = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] remaining;
    logic [3:0]  destination;
    logic [7:0]  data_byte;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  slot_index;
    logic        alloc_ok;
    logic [3:0]  expiry_destination;
    logic [7:0]  expiry_byte;
    logic [31:0] tick_count;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/mtt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_ram
// Slot table: one write port, one read port with registered read data.
// Entries never written read back as all zero (free).
// ----------------------------------------------------------------------------
module mtt_ram #(
  parameter int DEPTH = mtt_pkg::NUM_TIMERS_DEF,
  parameter int AW    = 5
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               we,
  input  wire [AW-1:0]      waddr,
  input  mtt_pkg::entry_t   wdata,
  input  wire               re,
  input  wire [AW-1:0]      raddr,
  output mtt_pkg::entry_t   rdata
);

  mtt_pkg::entry_t mem [DEPTH];
  mtt_pkg::entry_t rdata_r;
  logic [DEPTH-1:0] written_r;
  logic             rvalid_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Written bits stand in for a clearing pass over the table after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rvalid_r  <= 1'b0;
    end else begin
      if (we) begin
        written_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvalid_r <= written_r[raddr];
      end
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule
`default_nettype wire

// ===== sv/mtt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtt_ctrl
// Command sequencer: read-modify-write of slot entries, slot scans for
// allocate and tick, tick counter and the result register.
// ----------------------------------------------------------------------------
module mtt_ctrl #(
  parameter int NUM_TIMERS = mtt_pkg::NUM_TIMERS_DEF,
  parameter int AW         = 5
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [2:0]       in_command,
  input  wire  [4:0]       in_slot,
  input  wire  [3:0]       in_destination,
  input  wire  [7:0]       in_data_byte,
  input  wire  [31:0]      in_timeout,
  output logic             out_valid,
  input  wire              out_stall,
  output mtt_pkg::res_t    out_res,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output mtt_pkg::entry_t  mem_wdata,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  mtt_pkg::entry_t  mem_rdata
);

  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TIMERS - 1);
  localparam logic [6:0]    NUM_W    = 7'(NUM_TIMERS);

  mtt_pkg::state_t state_r, state_nxt;
  mtt_pkg::cmd_e_t cmd_r;
  logic [3:0]      dst_r;
  logic [7:0]      byte_r;
  logic [31:0]     tout_r;
  logic [31:0]     ticks_r;
  logic [AW-1:0]   idx_r;
  logic [5:0]      cnt_r;
  logic            held_valid_r;
  mtt_pkg::res_t   held_r;
  logic            out_valid_r;
  mtt_pkg::res_t   out_r;

  logic            accept;
  logic            known_cmd;
  logic            slot_ok;
  logic [6:0]      slot_ext;
  logic [6:0]      idx_ext;
  logic            out_free;
  logic            last_slot;
  logic            running;
  logic [31:0]     dec;
  logic            expire;
  logic            emit;
  logic            push;
  mtt_pkg::res_t   push_res;
  logic            idx_step;
  logic            held_load;
  logic            held_clear;
  mtt_pkg::res_t   expiry_res;

  assign in_stall  = (state_r != mtt_pkg::S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_ext  = 7'(in_slot);
  assign slot_ok   = slot_ext < NUM_W;
  assign idx_ext   = 7'(idx_r);
  assign out_free  = !out_valid_r || !out_stall;
  assign last_slot = (idx_r == LAST_IDX);
  assign running   = (mem_rdata.status == mtt_pkg::STAT_USING);
  assign dec       = mem_rdata.remaining - 32'd1;
  assign expire    = running && (dec == 32'd0);
  assign emit      = expire && (cnt_r < 6'(mtt_pkg::OUT_MAX));

  always_comb begin
    known_cmd = 1'b0;
    if (in_command inside {mtt_pkg::CMD_ALLOC, mtt_pkg::CMD_TICK}) begin
      known_cmd = 1'b1;
    end else if (in_command inside {mtt_pkg::CMD_FREE, mtt_pkg::CMD_SET,
                                    mtt_pkg::CMD_START}) begin
      known_cmd = slot_ok;
    end
  end

  always_comb begin
    expiry_res                    = '0;
    expiry_res.kind               = mtt_pkg::KIND_EXPIRY;
    expiry_res.slot_index         = idx_ext[4:0];
    expiry_res.expiry_destination = mem_rdata.destination;
    expiry_res.expiry_byte        = mem_rdata.data_byte;
    expiry_res.tick_count         = ticks_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mtt_pkg::S_IDLE: begin
        if (accept && known_cmd) begin
          state_nxt = mtt_pkg::S_READ;
        end
      end
      mtt_pkg::S_READ: begin
        state_nxt = mtt_pkg::S_EVAL;
      end
      mtt_pkg::S_EVAL: begin
        case (cmd_r)
          mtt_pkg::CMD_ALLOC: begin
            if (mem_rdata.status == mtt_pkg::STAT_FREE) begin
              if (out_free) begin
                state_nxt = mtt_pkg::S_IDLE;
              end
            end else if (last_slot) begin
              state_nxt = mtt_pkg::S_FINISH;
            end else begin
              state_nxt = mtt_pkg::S_READ;
            end
          end
          mtt_pkg::CMD_TICK: begin
            if (!(emit && held_valid_r && !out_free)) begin
              state_nxt = last_slot ? mtt_pkg::S_FINISH : mtt_pkg::S_READ;
            end
          end
          default: begin
            state_nxt = mtt_pkg::S_IDLE;
          end
        endcase
      end
      mtt_pkg::S_FINISH: begin
        if (out_free || (cmd_r == mtt_pkg::CMD_TICK && !held_valid_r)) begin
          state_nxt = mtt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mtt_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath controls.
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = mem_rdata;
    mem_re     = 1'b0;
    mem_raddr  = idx_r;
    push       = 1'b0;
    push_res   = '0;
    idx_step   = 1'b0;
    held_load  = 1'b0;
    held_clear = 1'b0;
    case (state_r)
      mtt_pkg::S_READ: begin
        mem_re = 1'b1;
      end
      mtt_pkg::S_EVAL: begin
        case (cmd_r)
          mtt_pkg::CMD_ALLOC: begin
            if (mem_rdata.status == mtt_pkg::STAT_FREE) begin
              if (out_free) begin
                mem_we              = 1'b1;
                mem_wdata.status    = mtt_pkg::STAT_ALLOC;
                push                = 1'b1;
                push_res.kind       = mtt_pkg::KIND_ALLOC;
                push_res.slot_index = idx_ext[4:0];
                push_res.alloc_ok   = 1'b1;
                push_res.last       = 1'b1;
              end
            end else begin
              idx_step = !last_slot;
            end
          end
          mtt_pkg::CMD_FREE: begin
            mem_we           = 1'b1;
            mem_wdata.status = mtt_pkg::STAT_FREE;
          end
          mtt_pkg::CMD_SET: begin
            mem_we                = 1'b1;
            mem_wdata.destination = dst_r;
            mem_wdata.data_byte   = byte_r;
          end
          mtt_pkg::CMD_START: begin
            mem_we              = 1'b1;
            mem_wdata.status    = mtt_pkg::STAT_USING;
            mem_wdata.remaining = tout_r;
          end
          mtt_pkg::CMD_TICK: begin
            if (!(emit && held_valid_r && !out_free)) begin
              mem_we              = running;
              mem_wdata.remaining = dec;
              mem_wdata.status    = expire ? mtt_pkg::STAT_ALLOC : mtt_pkg::STAT_USING;
              idx_step            = !last_slot;
              // A new expiry pushes the one held before it, which is then
              // known not to be the last transfer of this tick.
              if (emit) begin
                held_load = 1'b1;
                push      = held_valid_r;
                push_res  = held_r;
              end
            end
          end
          default: begin
          end
        endcase
      end
      mtt_pkg::S_FINISH: begin
        if (cmd_r == mtt_pkg::CMD_ALLOC) begin
          push          = out_free;
          push_res.kind = mtt_pkg::KIND_ALLOC;
          push_res.last = 1'b1;
        end else begin
          push          = out_free && held_valid_r;
          push_res      = held_r;
          push_res.last = 1'b1;
          held_clear    = out_free;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mtt_pkg::S_IDLE;
      cmd_r        <= mtt_pkg::CMD_ALLOC;
      ticks_r      <= '0;
      idx_r        <= '0;
      cnt_r        <= '0;
      held_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && known_cmd) begin
        cmd_r   <= mtt_pkg::cmd_e_t'(in_command);
        cnt_r   <= '0;
        idx_r   <= (in_command == mtt_pkg::CMD_ALLOC || in_command == mtt_pkg::CMD_TICK)
                   ? '0 : slot_ext[AW-1:0];
        if (in_command == mtt_pkg::CMD_TICK) begin
          ticks_r <= ticks_r + 32'd1;
        end
      end else if (idx_step) begin
        idx_r <= idx_r + AW'(1);
      end
      if (held_load) begin
        held_valid_r <= 1'b1;
        cnt_r        <= cnt_r + 6'd1;
      end else if (held_clear) begin
        held_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dst_r  <= in_destination;
      byte_r <= in_data_byte;
      tout_r <= in_timeout;
    end
    if (held_load) begin
      held_r <= expiry_res;
    end
    if (push) begin
      out_r <= push_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule
`default_nettype wire

// ===== sv/multi_timer_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_timer_table
// Table of countdown timers with allocate, free, set, start and tick.
//
//   Channel   Ports                         Moves
//   in_       in_valid / in_stall           one command per transfer
//   out_      out_valid / out_stall         one reply or expiry per transfer
//
// Each slot entry is handled by a read and an evaluate state on the table
// memory. Free, set and start handle their one slot; allocate scans slots
// up to the first free one, or all slots and then a finish state when none
// is free; tick scans every slot and then the finish state. Both may wait
// on out_stall. Unknown commands are taken and dropped without a reply.
// rst_n clears all slots to free and the tick counter to zero at once.
// The held-expiry register lets the tick scan run on while one transfer waits.
// ----------------------------------------------------------------------------
module multi_timer_table #(
  parameter int NUM_TIMERS = mtt_pkg::NUM_TIMERS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_command,
  input  wire  [4:0]  in_slot,
  input  wire  [3:0]  in_destination,
  input  wire  [7:0]  in_data_byte,
  input  wire  [31:0] in_timeout,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_kind,
  output logic [4:0]  out_slot_index,
  output logic        out_alloc_ok,
  output logic [3:0]  out_expiry_destination,
  output logic [7:0]  out_expiry_byte,
  output logic [31:0] out_tick_count,
  output logic        out_last
);

  localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  mtt_pkg::res_t   res;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  mtt_pkg::entry_t mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  mtt_pkg::entry_t mem_rdata;

  mtt_ctrl #(
    .NUM_TIMERS (NUM_TIMERS),
    .AW         (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_slot        (in_slot),
    .in_destination (in_destination),
    .in_data_byte   (in_data_byte),
    .in_timeout     (in_timeout),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_res        (res),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  mtt_ram #(
    .DEPTH (NUM_TIMERS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_kind               = res.kind;
  assign out_slot_index         = res.slot_index;
  assign out_alloc_ok           = res.alloc_ok;
  assign out_expiry_destination = res.expiry_destination;
  assign out_expiry_byte        = res.expiry_byte;
  assign out_tick_count         = res.tick_count;
  assign out_last               = res.last;

endmodule
`default_nettype wire
